/* hw/rtl/sidta_pkg.sv */
// Shared constants, types and the helper function of the decimal text converter.
`timescale 1ns / 1ps
package sidta_pkg;

	localparam int VALUE_W = 32;
	localparam int DIGITS = 10;
	localparam int BCD_W = 4 * DIGITS;
	localparam int BIT_CNT_W = $clog2(VALUE_W);
	localparam int DIG_CNT_W = $clog2(DIGITS + 1);
	localparam int CHAR_W = 6;

	localparam logic [CHAR_W-1:0] CH_ZERO = CHAR_W'(48);
	localparam logic [CHAR_W-1:0] CH_MINUS = CHAR_W'(45);

	typedef struct packed {
		logic             valid;
		logic             negative;
		logic [BCD_W-1:0] bcd;
	} bcd_word_t;

	function automatic logic [3:0] dabble_adjust(input logic [3:0] d);
		logic [3:0] r;
		r = (d >= 4'd5) ? d + 4'd3 : d;
		return r;
	endfunction

endpackage

/* hw/rtl/sidta_dabble.sv */
// Bit-serial binary to packed decimal conversion by shift and add-three.
`timescale 1ns / 1ps
module sidta_dabble
	import sidta_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      load,
	input  logic signed [VALUE_W-1:0] value,
	output logic                      running,
	output bcd_word_t                 result
);

	logic [VALUE_W-1:0]   mag_q;
	logic [BCD_W-1:0]     bcd_q;
	logic [BIT_CNT_W-1:0] cnt_q;
	logic                 run_q;
	logic                 done_q;
	logic                 neg_q;
	logic [BCD_W-1:0]     adj;

	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			adj[4*i +: 4] = dabble_adjust(bcd_q[4*i +: 4]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (load) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == BIT_CNT_W'(VALUE_W - 1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			neg_q <= value[VALUE_W-1];
			mag_q <= value[VALUE_W-1] ? (~value + 1'b1) : value;
			bcd_q <= '0;
		end else if (run_q) begin
			{bcd_q, mag_q} <= {adj[BCD_W-2:0], mag_q, 1'b0};
		end
	end

	assign running = run_q | done_q;
	assign result.valid = done_q;
	assign result.negative = neg_q;
	assign result.bcd = bcd_q;

endmodule

/* hw/rtl/sidta_emit.sv */
// Character serializer that drops leading zeros and sends one word per cycle from its first sent digit on.
`timescale 1ns / 1ps
module sidta_emit
	import sidta_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  bcd_word_t         src,
	output logic              running,
	output logic              strobe,
	output logic [CHAR_W-1:0] character,
	output logic              last
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SIGN  = 4'b0010,
		ST_SKIP  = 4'b0100,
		ST_DIGIT = 4'b1000
	} emit_state_t;

	emit_state_t          state_q;
	logic [BCD_W-1:0]     bcd_q;
	logic [DIG_CNT_W-1:0] cnt_q;
	logic                 strobe_q;
	logic [CHAR_W-1:0]    char_q;
	logic                 last_q;
	logic [3:0]           top;
	logic                 final_digit;

	assign top = bcd_q[BCD_W-1 -: 4];
	assign final_digit = (cnt_q == DIG_CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (src.valid) begin
						state_q <= src.negative ? ST_SIGN : ST_SKIP;
					end
				end
				ST_SIGN: begin
					strobe_q <= 1'b1;
					state_q <= ST_SKIP;
				end
				ST_SKIP: begin
					if (top != 4'd0 || final_digit) begin
						strobe_q <= 1'b1;
						state_q <= final_digit ? ST_IDLE : ST_DIGIT;
					end
				end
				ST_DIGIT: begin
					strobe_q <= 1'b1;
					if (final_digit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				bcd_q <= src.bcd;
				cnt_q <= DIG_CNT_W'(DIGITS);
			end
			ST_SIGN: begin
				char_q <= CH_MINUS;
				last_q <= 1'b0;
			end
			ST_SKIP, ST_DIGIT: begin
				char_q <= CH_ZERO + {2'b00, top};
				last_q <= final_digit;
				bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
				cnt_q <= cnt_q - 1'b1;
			end
			default: begin
				bcd_q <= bcd_q;
			end
		endcase
	end

	assign running = (state_q != ST_IDLE);
	assign strobe = strobe_q;
	assign character = char_q;
	assign last = last_q;

endmodule

/* hw/rtl/signed_int_to_decimal_ascii.sv */
// Top level of the signed 32-bit integer to decimal ASCII text converter.
//
//   channel   ports                 handshake
//   input     value                 start high and busy low
//   result    character, last       strobe high for one cycle
//
// A conversion runs shift-and-add-three over the 32 bits of the magnitude, hands the
// packed digits to the serializer, sends the sign if there is one, steps through each
// of the ten decimal positions, sent or dropped, and registers each word for the ports.
// Reset leaves the block idle with busy low and no strobe.
// The receiver cannot stall; busy falls while the last word is on the ports.
`timescale 1ns / 1ps
module signed_int_to_decimal_ascii
	import sidta_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic signed [VALUE_W-1:0] value,
	output logic                      strobe,
	output logic [CHAR_W-1:0]         character,
	output logic                      last
);

	logic      load;
	logic      conv_running;
	logic      emit_running;
	bcd_word_t bcd_word;

	assign load = start & ~busy;
	assign busy = conv_running | emit_running;

	sidta_dabble u_dabble (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (load),
		.value   (value),
		.running (conv_running),
		.result  (bcd_word)
	);

	sidta_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.src       (bcd_word),
		.running   (emit_running),
		.strobe    (strobe),
		.character (character),
		.last      (last)
	);

endmodule

/* sim/testbench.sv */
// Self-checking testbench of the signed integer to decimal ASCII text converter.
`timescale 1ns / 1ps
module testbench;
	import sidta_pkg::*;

	typedef struct packed {
		logic [CHAR_W-1:0] character;
		logic              last;
	} text_char_t;

	class decimal_text_scoreboard;
		text_char_t pending_chars[$];
		int         errors;
		int         chars_checked;

		function void note_value(input logic [VALUE_W-1:0] raw);
			logic             negative;
			logic [VALUE_W-1:0] magnitude;
			logic [3:0]       digits[DIGITS];
			int               count;
			int               i;
			negative = raw[VALUE_W-1];
			magnitude = negative ? -raw : raw;
			count = 0;
			do begin
				digits[count] = 4'(magnitude % 32'd10);
				magnitude = magnitude / 32'd10;
				count++;
			end while (magnitude != 0 && count < DIGITS);
			if (negative) begin
				pending_chars.push_back('{character: CH_MINUS, last: 1'b0});
			end
			for (i = count - 1; i >= 0; i--) begin
				pending_chars.push_back('{character: CH_ZERO + CHAR_W'(digits[i]),
					last: (i == 0)});
			end
		endfunction

		function void check_char(input logic [CHAR_W-1:0] character, input logic last);
			text_char_t want;
			chars_checked++;
			if (pending_chars.size() == 0) begin
				errors++;
				$display("%0t: unexpected word, got character %0d last %0b",
					$time, character, last);
				return;
			end
			want = pending_chars.pop_front();
			if (character !== want.character) begin
				errors++;
				$display("%0t: character mismatch, expected %0d, actual %0d",
					$time, want.character, character);
			end
			if (last !== want.last) begin
				errors++;
				$display("%0t: last mismatch, expected %0b, actual %0b",
					$time, want.last, last);
			end
		endfunction

		function int pending();
			return pending_chars.size();
		endfunction
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      start = 1'b0;
	logic                      busy;
	logic signed [VALUE_W-1:0] value = '0;
	logic                      strobe;
	logic [CHAR_W-1:0]         character;
	logic                      last;

	decimal_text_scoreboard sb = new;
	int values_sent = 0;
	int negatives_sent = 0;
	int burst_left = 0;

	signed_int_to_decimal_ascii i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.value     (value),
		.strobe    (strobe),
		.character (character),
		.last      (last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && strobe) begin
			sb.check_char(character, last);
		end
	end

	task automatic send_value(input logic [VALUE_W-1:0] v);
		start <= 1'b1;
		value <= v;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_value(v);
		values_sent++;
		if (v[VALUE_W-1]) begin
			negatives_sent++;
		end
	endtask

	task automatic idle_for(input int cycles);
		if (cycles > 0) begin
			start <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	task automatic send_paced(input logic [VALUE_W-1:0] v);
		if (burst_left == 0) begin
			idle_for(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40));
			burst_left = $urandom_range(1, 10);
		end
		burst_left--;
		send_value(v);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	function automatic logic [VALUE_W-1:0] random_value();
		longint low;
		longint high;
		logic [VALUE_W-1:0] magnitude;
		int digit_count;
		case ($urandom_range(0, 3))
			0, 1: begin
				digit_count = $urandom_range(1, DIGITS);
				low = 1;
				repeat (digit_count - 1) low = low * 10;
				high = low * 10 - 1;
				if (digit_count == 1) begin
					low = 0;
				end
				if (high > 64'sd2147483647) begin
					high = 64'sd2147483647;
				end
				magnitude = $urandom_range(32'(high), 32'(low));
			end
			2: begin
				return $urandom();
			end
			default: begin
				low = 1;
				repeat ($urandom_range(0, DIGITS - 1)) low = low * 10;
				magnitude = 32'(low) + $urandom_range(0, 2) - 1;
			end
		endcase
		return $urandom_range(0, 1) ? -magnitude : magnitude;
	endfunction

	initial begin
		logic [VALUE_W-1:0] directed[$];
		directed = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
			-32'sd100, 32'd2147483647, 32'h80000000, -32'sd2147483647,
			32'd1000000000, 32'd999999999, -32'sd999999999, -32'sd1000000000,
			32'd123456789, -32'sd987654321, 32'h55555555, 32'hAAAAAAAA,
			32'd1000000001, -32'sd9, 32'd4294967286, 32'd7, 32'hFFFF0000};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[n]) begin
			send_paced(directed[n]);
		end
		repeat (140) send_paced(random_value());
		// The sender holds back here until every character has come out.
		drain();
		repeat (140) send_paced(random_value());
		drain();
		$display("Converted %0d values (%0d negative) and checked %0d characters.",
			values_sent, negatives_sent, sb.chars_checked);
		$display("Sender bursts and gaps, one full drain mid-run, extremes and zero.");
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Timeout with %0d characters still expected.", sb.pending());
		$display("testbench: done, errors");
		$finish;
	end

endmodule
